[design/tcgp_pkg.sv]
// ----------------------------------------------------------------------------
// tcgp_pkg
// Shared types and constants of the text cursor glyph placer.
// ----------------------------------------------------------------------------
package tcgp_pkg;

    localparam int COLS_DEF       = 40;
    localparam int ROWS_DEF       = 25;
    localparam int COUNT_BITS_DEF = 12;

    localparam int Q_DEPTH = 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 96;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    localparam logic [5:0] GLYPH_BLANK  = 6'd0;
    localparam logic [5:0] GLYPH_DIGIT0 = 6'd27;
    localparam logic [5:0] GLYPH_QUOTE  = 6'd38;
    localparam logic [5:0] GLYPH_PERIOD = 6'd39;
    localparam logic [5:0] GLYPH_GT     = 6'd40;
    localparam logic [5:0] GLYPH_SLASH  = 6'd41;
    localparam logic [5:0] GLYPH_BAR    = 6'd42;
    localparam logic [5:0] GLYPH_COMMA  = 6'd43;
    localparam logic [5:0] GLYPH_LAST   = 6'd43;

    localparam logic [5:0] ROW_SAT = 6'd63;

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        OP_END,
        OP_DRAW,
        OP_MOVE,
        OP_NL,
        OP_BS
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        first;
        logic [7:0]  start_col;
        logic [7:0]  start_row;
        logic [5:0]  glyph;
        logic [11:0] offset;
        logic [7:0]  color;
        logic        overlay;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [5:0]  glyph_index;
        logic [31:0] glyph_address;
        logic [8:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [7:0]  draw_color;
        logic        draw_overlay;
        logic [11:0] final_count;
        logic [5:0]  final_col;
        logic [5:0]  final_row;
    } t_result;

endpackage

[design/tcgp_front.sv]
// ----------------------------------------------------------------------------
// tcgp_front
// Classify one character byte: operation, glyph number and font offset.
// ----------------------------------------------------------------------------
module tcgp_front (
    input  logic [7:0]     i_char_code,
    input  logic           i_first,
    input  logic [7:0]     i_start_col,
    input  logic [7:0]     i_start_row,
    input  logic [7:0]     i_color,
    input  logic           i_overlay,
    output tcgp_pkg::t_item o_item
);
    import tcgp_pkg::*;

    t_op        op;
    logic [5:0] glyph;
    logic       blank;
    logic [7:0] c;

    assign c = i_char_code;

    always_comb begin
        op    = OP_MOVE;
        glyph = GLYPH_BLANK;
        blank = 1'b0;
        if (c == CH_END) begin
            op = OP_END;
        end else if (c == CH_BS) begin
            op = OP_BS;
        end else if (c == CH_NL) begin
            op = OP_NL;
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            op    = OP_DRAW;
            glyph = 6'(c - 8'h40);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            op    = OP_DRAW;
            glyph = 6'(c - 8'h60);
        end else if (c >= 8'h30 && c <= 8'h3A) begin
            op    = OP_DRAW;
            glyph = 6'(c - 8'h30) + GLYPH_DIGIT0;
        end else begin
            case (c)
                CH_SPACE:  begin op = OP_DRAW; glyph = GLYPH_BLANK; blank = 1'b1; end
                CH_PERIOD: begin op = OP_DRAW; glyph = GLYPH_PERIOD; end
                CH_SLASH:  begin op = OP_DRAW; glyph = GLYPH_SLASH; end
                CH_GT:     begin op = OP_DRAW; glyph = GLYPH_GT; end
                CH_QUOTE:  begin op = OP_DRAW; glyph = GLYPH_QUOTE; end
                CH_COMMA:  begin op = OP_DRAW; glyph = GLYPH_COMMA; end
                CH_BAR:    begin op = OP_DRAW; glyph = GLYPH_BAR; end
                default:   begin op = OP_MOVE; end
            endcase
        end
    end

    // 75 * glyph as shifts and adds
    always_comb begin
        o_item.op        = op;
        o_item.first     = i_first;
        o_item.start_col = i_start_col;
        o_item.start_row = i_start_row;
        o_item.glyph     = glyph;
        o_item.offset    = {glyph, 6'b0} + {3'b0, glyph, 3'b0}
                         + {5'b0, glyph, 1'b0} + {6'b0, glyph};
        o_item.color     = i_color;
        o_item.overlay   = blank | i_overlay;
    end

endmodule

[design/tcgp_queue.sv]
// ----------------------------------------------------------------------------
// tcgp_queue
// Short register queue between the classifier and the cursor engine.
// ----------------------------------------------------------------------------
module tcgp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcgp_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output tcgp_pkg::t_item o_item
);
    import tcgp_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(Q_DEPTH - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

[design/tcgp_back.sv]
// ----------------------------------------------------------------------------
// tcgp_back
// Cursor engine: move the cursor, count, latch stops, build results.
// ----------------------------------------------------------------------------
module tcgp_back #(
    parameter int COLS       = tcgp_pkg::COLS_DEF,
    parameter int ROWS       = tcgp_pkg::ROWS_DEF,
    parameter int COUNT_BITS = tcgp_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              i_valid,
    input  tcgp_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tcgp_pkg::t_result o_result
);
    import tcgp_pkg::*;

    localparam logic [5:0] COL_LAST  = 6'(COLS - 1);
    localparam logic [5:0] ROW_LAST  = 6'(ROWS - 1);
    localparam logic [7:0] COL_LIM   = 8'(COLS - 1);
    localparam logic [7:0] ROW_LIM   = 8'(ROWS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [31:0]           r_font_base;
    logic [5:0]            r_col, n_col;
    logic [5:0]            r_row, n_row;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_stopped, n_stopped;
    logic                  r_invalid, n_invalid;
    logic                  r_out_valid;
    t_result               r_out, n_out;

    logic [5:0]            e_col, e_row;
    logic [COUNT_BITS-1:0] e_count, count_inc;
    logic                  e_stopped, e_invalid;
    logic                  emit;
    logic                  load;

    assign load    = !r_out_valid || i_ready;
    assign o_pop   = i_valid && load;
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        if (i_item.first) begin
            e_col     = i_item.start_col[5:0];
            e_row     = i_item.start_row[5:0];
            e_count   = '0;
            e_stopped = 1'b0;
            e_invalid = !(i_item.start_col <= COL_LIM && i_item.start_row <= ROW_LIM);
        end else begin
            e_col     = r_col;
            e_row     = r_row;
            e_count   = r_count;
            e_stopped = r_stopped;
            e_invalid = r_invalid;
        end
        count_inc = (e_count == COUNT_MAX) ? e_count : e_count + 1'b1;
    end

    always_comb begin
        n_col     = e_col;
        n_row     = e_row;
        n_count   = e_count;
        n_stopped = e_stopped;
        n_invalid = e_invalid;
        emit      = 1'b0;
        n_out     = '0;
        n_out.kind          = KIND_DRAW;
        n_out.glyph_index   = i_item.glyph;
        n_out.glyph_address = r_font_base + 32'(i_item.offset);
        n_out.pixel_x       = {e_col, 3'b0};
        n_out.pixel_y       = {e_row, 3'b0};
        n_out.draw_color    = i_item.color;
        n_out.draw_overlay  = i_item.overlay;
        case (i_item.op)
            OP_END: begin
                emit  = 1'b1;
                n_out = '0;
                n_out.kind        = KIND_REPORT;
                n_out.final_count = 12'(e_count);
                n_out.final_col   = e_col;
                n_out.final_row   = e_row;
            end
            OP_DRAW, OP_MOVE, OP_NL: begin
                if (!e_stopped && !e_invalid) begin
                    emit = (i_item.op == OP_DRAW);
                    if (e_col < COL_LAST && i_item.op != OP_NL) begin
                        n_col   = e_col + 1'b1;
                        n_count = count_inc;
                    end else if (e_row < ROW_LAST || i_item.op == OP_NL) begin
                        n_col   = '0;
                        n_row   = (e_row == ROW_SAT) ? e_row : e_row + 1'b1;
                        n_count = count_inc;
                    end else begin
                        n_stopped = 1'b1;
                    end
                end
            end
            OP_BS: begin
                if (!e_stopped && !e_invalid) begin
                    if (e_col != '0) begin
                        n_col = e_col - 1'b1;
                    end else if (e_row != '0) begin
                        n_col = COL_LAST;
                        n_row = e_row - 1'b1;
                    end else begin
                        n_stopped = 1'b1;
                    end
                    if (!n_stopped) begin
                        emit    = 1'b1;
                        n_count = count_inc;
                        n_out.glyph_index   = GLYPH_BLANK;
                        n_out.glyph_address = r_font_base;
                        n_out.pixel_x       = {n_col, 3'b0};
                        n_out.pixel_y       = {n_row, 3'b0};
                        n_out.draw_overlay  = 1'b1;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_base <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_count     <= '0;
            r_stopped   <= 1'b0;
            r_invalid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_font_base <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_count   <= n_count;
                r_stopped <= n_stopped;
                r_invalid <= n_invalid;
            end
            if (o_pop && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out <= n_out;
        end
    end

endmodule

[design/text_cursor_glyph_placer_unit.sv]
// ----------------------------------------------------------------------------
// text_cursor_glyph_placer_unit
// Text console engine: turns character bytes into glyph draw requests and end-of-string reports.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one character byte per transfer; tuser marks the
// first byte of a string, whose tdata also brings the start column and row.
// A zero byte ends the string and yields one report transfer on m_axis
// (tuser = 1) with count and final cursor; printable bytes and backspace
// yield one draw transfer (tuser = 0); newline, unsupported bytes and bytes
// after a stop yield nothing.
// An input transfer is classified into a two-entry queue, and the cursor engine
// pops it from there into the output register.
// Throughput is one byte per cycle while m_axis takes results.
// When m_axis stalls, the output register holds, the queue fills, and
// s_axis_tready drops once both queue entries are taken.
// i_cfg_we writes font_base from i_cfg_wdata; write it only while idle.
// Reset clears cursor, count, stop flags, font_base, queue and output valid.
// ----------------------------------------------------------------------------
module text_cursor_glyph_placer_unit #(
    parameter int COLS       = tcgp_pkg::COLS_DEF,
    parameter int ROWS       = tcgp_pkg::ROWS_DEF,
    parameter int COUNT_BITS = tcgp_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [31:0]                   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // char_code[7:0], start_col[15:8], start_row[23:16], color[31:24],
    // overlay[32], zero fill[39:33]
    input  logic [tcgp_pkg::S_DATA_W-1:0] s_axis_tdata,
    // first[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // glyph_index[5:0], glyph_address[37:6], pixel_x[46:38], pixel_y[55:47],
    // draw_color[63:56], draw_overlay[64], final_count[76:65],
    // final_col[82:77], final_row[88:83], zero fill[95:89]
    output logic [tcgp_pkg::M_DATA_W-1:0] m_axis_tdata,
    // kind[0]
    output logic                          m_axis_tuser
);
    import tcgp_pkg::*;

    t_item   front_item;
    t_item   q_item;
    t_result result;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;
    logic    s_xfer;

    assign s_axis_tready = !q_full;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    tcgp_front u_front (
        .i_char_code (s_axis_tdata[7:0]),
        .i_first     (s_axis_tuser),
        .i_start_col (s_axis_tdata[15:8]),
        .i_start_row (s_axis_tdata[23:16]),
        .i_color     (s_axis_tdata[31:24]),
        .i_overlay   (s_axis_tdata[32]),
        .o_item      (front_item)
    );

    tcgp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_xfer),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    tcgp_back #(
        .COLS       (COLS),
        .ROWS       (ROWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tuser = result.kind;
    assign m_axis_tdata = {7'b0,
                           result.final_row,
                           result.final_col,
                           result.final_count,
                           result.draw_overlay,
                           result.draw_color,
                           result.pixel_y,
                           result.pixel_x,
                           result.glyph_address,
                           result.glyph_index};

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_REPORT) |-> (m_axis_tdata[64:0] == '0))
        else $error("report carries draw fields");

    a_draw_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DRAW) |->
            (m_axis_tdata[88:65] == '0 && m_axis_tdata[5:0] <= GLYPH_LAST))
        else $error("draw carries report fields or bad glyph");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !q_pop) |=> q_valid)
        else $error("queued item lost");

endmodule
